FILE: rtl/btsr_pkg.sv
// ----------------------------------------------------------------------------
// btsr_pkg: battery telemetry sensor responder definitions
// Event codes, register indexes, voltage scale and the fuel level table.
// ----------------------------------------------------------------------------
package btsr_pkg;

  typedef enum logic [1:0] {
    MODE_GOOD = 2'd0,
    MODE_BAD  = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DISCOVER_CODE   = 3'd0,
    REG_TYPE_QUERY_CODE = 3'd1,
    REG_READ_CODE       = 3'd2,
    REG_VOLT_TYPE_CODE  = 3'd3,
    REG_FUEL_TYPE_CODE  = 3'd4,
    REG_FUEL_DISC_EN    = 3'd5,
    REG_STARTUP_TICKS   = 3'd6,
    REG_UNUSED          = 3'd7
  } reg_index_t;

  localparam logic [3:0]  VOLT_SENSOR_ID = 4'd1;
  localparam logic [3:0]  FUEL_SENSOR_ID = 4'd2;
  localparam logic [1:0]  PAYLOAD_LEN    = 2'd2;
  localparam logic [7:0]  TYPE_HIGH_BYTE = 8'd2;
  localparam logic [7:0]  FULL_PERCENT   = 8'd100;
  localparam logic [15:0] TICK_MAX       = 16'hFFFF;

  // 0.01 V per LSB: sample * 33 * 57 >> 8
  localparam int VOLT_SCALE = 33 * 57;
  localparam int VOLT_W     = 13;
  localparam int PROD_W     = 21;

  localparam int LEVEL_ROWS = 21;
  localparam int PACK_SIZES = 2;

  localparam logic [VOLT_W-1:0] LEVEL_TABLE [PACK_SIZES][LEVEL_ROWS] = '{
    '{13'd982,  13'd1083, 13'd1106, 13'd1112, 13'd1118, 13'd1124, 13'd1130,
      13'd1136, 13'd1139, 13'd1145, 13'd1151, 13'd1156, 13'd1162, 13'd1174,
      13'd1186, 13'd1195, 13'd1207, 13'd1225, 13'd1233, 13'd1245, 13'd1260},
    '{13'd1309, 13'd1443, 13'd1475, 13'd1483, 13'd1491, 13'd1499, 13'd1506,
      13'd1514, 13'd1518, 13'd1526, 13'd1534, 13'd1542, 13'd1550, 13'd1566,
      13'd1581, 13'd1593, 13'd1609, 13'd1633, 13'd1645, 13'd1660, 13'd1680}
  };

endpackage

FILE: rtl/battery_telemetry_sensor_responder.sv
// ----------------------------------------------------------------------------
// battery_telemetry_sensor_responder
// Answers telemetry bus polls for a voltage sensor and a fuel percent sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event per transaction:
//   good packet (command, sensor_id, adc_sample), bad packet, time tick or none.
//   Every input transaction yields exactly one output transaction
//   (out_valid/out_ready); reply_valid says whether a reply packet is sent,
//   led_on always gives the status light after the event.
//   Each event passes the input register, then the result register. One
//   transaction per cycle is sustained while the receiver does not stall;
//   the whole reply, including the constant multiply and the level table
//   compares, is produced in the single logic stage between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes a transaction only while empty; once full, in_ready drops.
//   Reset clears the tick counter, startup flag, stored voltage and LED and
//   loads the register defaults. cfg_we writes register cfg_index directly.
// ----------------------------------------------------------------------------
module battery_telemetry_sensor_responder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic [3:0]                        command,
  input  logic [3:0]                        sensor_id,
  input  logic [9:0]                        adc_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              reply_valid,
  output logic [3:0]                        reply_command,
  output logic [3:0]                        reply_sensor,
  output logic [1:0]                        reply_length,
  output logic [7:0]                        payload_low,
  output logic [7:0]                        payload_high,
  output logic                              led_on,
  input  logic                              cfg_we,
  input  logic [btsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [btsr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int VW = btsr_pkg::VOLT_W;
  localparam int MID_ROWS = btsr_pkg::LEVEL_ROWS - 2;

  // configuration
  logic [3:0]  discover_code;
  logic [3:0]  type_query_code;
  logic [3:0]  read_code;
  logic [7:0]  voltage_type_code;
  logic [7:0]  fuel_type_code;
  logic        fuel_discover_enable;
  logic [15:0] startup_ticks;

  // block state
  logic [15:0]   tick_count;
  logic          startup_over;
  logic [VW-1:0] last_voltage;
  logic          led_state;

  // input register
  logic                s1_valid;
  btsr_pkg::mode_t     s1_mode;
  logic [3:0]          s1_command;
  logic [3:0]          s1_sensor;
  logic [9:0]          s1_adc;
  logic                s1_advance;

  // next values
  logic [15:0]   tick_count_next;
  logic          startup_over_next;
  logic [VW-1:0] last_voltage_next;
  logic          led_state_next;
  logic          rv_next;
  logic [1:0]    len_next;
  logic [7:0]    lo_next;
  logic [7:0]    hi_next;

  // datapath
  logic [btsr_pkg::PROD_W-1:0] volt_prod;
  logic [VW-1:0]               volt_new;
  logic                        in_pack0;
  logic                        in_pack1;
  logic                        pack_sel;
  logic [MID_ROWS-1:0]         above_row;
  logic [4:0]                  row_count;
  logic [6:0]                  table_percent;
  logic [7:0]                  fuel_value;
  logic                        startup_active;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  assign volt_prod = btsr_pkg::PROD_W'(s1_adc) *
                     btsr_pkg::PROD_W'(btsr_pkg::VOLT_SCALE);
  assign volt_new  = volt_prod[btsr_pkg::PROD_W-1 -: VW];

  assign in_pack0 = (last_voltage >= btsr_pkg::LEVEL_TABLE[0][0]) &&
                    (last_voltage <= btsr_pkg::LEVEL_TABLE[0][btsr_pkg::LEVEL_ROWS-1]);
  assign in_pack1 = (last_voltage >= btsr_pkg::LEVEL_TABLE[1][0]) &&
                    (last_voltage <= btsr_pkg::LEVEL_TABLE[1][btsr_pkg::LEVEL_ROWS-1]);
  assign pack_sel = !in_pack0;

  // rows strictly below the voltage, bottom and top rows excluded: 5% each
  always_comb begin
    for (int r = 0; r < MID_ROWS; r++) begin
      above_row[r] = last_voltage > btsr_pkg::LEVEL_TABLE[pack_sel][r+1];
    end
  end

  assign row_count     = 5'($countones(above_row));
  assign table_percent = {row_count, 2'b00} + 7'(row_count);
  assign startup_active = !startup_over && (tick_count < startup_ticks);

  always_comb begin
    if (startup_active) begin
      fuel_value = btsr_pkg::FULL_PERCENT;
    end else if (in_pack0 || in_pack1) begin
      fuel_value = 8'(table_percent);
    end else begin
      fuel_value = '0;
    end
  end

  always_comb begin
    tick_count_next   = tick_count;
    startup_over_next = startup_over;
    last_voltage_next = last_voltage;
    led_state_next    = led_state;
    rv_next           = 1'b0;
    len_next          = '0;
    lo_next           = '0;
    hi_next           = '0;
    unique case (s1_mode)
      btsr_pkg::MODE_GOOD: begin
        led_state_next = 1'b1;
        priority if (s1_command == discover_code) begin
          rv_next = (s1_sensor == btsr_pkg::VOLT_SENSOR_ID) ||
                    ((s1_sensor == btsr_pkg::FUEL_SENSOR_ID) && fuel_discover_enable);
        end else if (s1_command == type_query_code) begin
          if (s1_sensor == btsr_pkg::VOLT_SENSOR_ID) begin
            rv_next  = 1'b1;
            len_next = btsr_pkg::PAYLOAD_LEN;
            lo_next  = voltage_type_code;
            hi_next  = btsr_pkg::TYPE_HIGH_BYTE;
          end else if (s1_sensor == btsr_pkg::FUEL_SENSOR_ID) begin
            rv_next  = 1'b1;
            len_next = btsr_pkg::PAYLOAD_LEN;
            lo_next  = fuel_type_code;
            hi_next  = btsr_pkg::TYPE_HIGH_BYTE;
          end
        end else if (s1_command == read_code) begin
          if (s1_sensor == btsr_pkg::VOLT_SENSOR_ID) begin
            last_voltage_next = volt_new;
            rv_next  = 1'b1;
            len_next = btsr_pkg::PAYLOAD_LEN;
            lo_next  = volt_new[7:0];
            hi_next  = 8'(volt_new[VW-1:8]);
          end else if (s1_sensor == btsr_pkg::FUEL_SENSOR_ID) begin
            if (!startup_active) begin
              startup_over_next = 1'b1;
            end
            rv_next  = 1'b1;
            len_next = btsr_pkg::PAYLOAD_LEN;
            lo_next  = fuel_value;
          end
        end
      end
      btsr_pkg::MODE_BAD: begin
        led_state_next = 1'b0;
      end
      btsr_pkg::MODE_TICK: begin
        if (tick_count != btsr_pkg::TICK_MAX) begin
          tick_count_next = tick_count + 16'd1;
        end
      end
      btsr_pkg::MODE_NONE: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      discover_code        <= 4'd8;
      type_query_code      <= 4'd9;
      read_code            <= 4'd10;
      voltage_type_code    <= 8'd3;
      fuel_type_code       <= 8'd6;
      fuel_discover_enable <= 1'b0;
      startup_ticks        <= 16'd2;
    end else if (cfg_we) begin
      unique case (btsr_pkg::reg_index_t'(cfg_index))
        btsr_pkg::REG_DISCOVER_CODE:   discover_code        <= cfg_data[3:0];
        btsr_pkg::REG_TYPE_QUERY_CODE: type_query_code      <= cfg_data[3:0];
        btsr_pkg::REG_READ_CODE:       read_code            <= cfg_data[3:0];
        btsr_pkg::REG_VOLT_TYPE_CODE:  voltage_type_code    <= cfg_data[7:0];
        btsr_pkg::REG_FUEL_TYPE_CODE:  fuel_type_code       <= cfg_data[7:0];
        btsr_pkg::REG_FUEL_DISC_EN:    fuel_discover_enable <= cfg_data[0];
        btsr_pkg::REG_STARTUP_TICKS:   startup_ticks        <= cfg_data;
        btsr_pkg::REG_UNUSED: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode    <= btsr_pkg::mode_t'(mode);
      s1_command <= command;
      s1_sensor  <= sensor_id;
      s1_adc     <= adc_sample;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      startup_over <= 1'b0;
      last_voltage <= '0;
      led_state    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (s1_advance) begin
        tick_count   <= tick_count_next;
        startup_over <= startup_over_next;
        last_voltage <= last_voltage_next;
        led_state    <= led_state_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      reply_valid   <= rv_next;
      reply_command <= rv_next ? s1_command : 4'd0;
      reply_sensor  <= rv_next ? s1_sensor : 4'd0;
      reply_length  <= len_next;
      payload_low   <= lo_next;
      payload_high  <= hi_next;
      led_on        <= led_state_next;
    end
  end

endmodule

FILE: dv/tb_battery_telemetry_sensor_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_telemetry_sensor_responder
// Drives telemetry events (good packet, bad packet, tick, none) through the
// valid/ready input channel and checks every reply transaction against an
// in-bench prediction of the responder. The run covers directed polls,
// the end of the startup window, and random traffic under several register
// settings and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_battery_telemetry_sensor_responder;

  localparam int CYCLE_LIMIT = 40000;

  typedef struct packed {
    logic       valid;
    logic [3:0] command;
    logic [3:0] sensor;
    logic [1:0] length;
    logic [7:0] low;
    logic [7:0] high;
    logic       led;
  } reply_t;

  // Tracks responder state and the queue of replies still owed by the block.
  class reply_tracker;
    logic [3:0]                  discover_code;
    logic [3:0]                  type_query_code;
    logic [3:0]                  read_code;
    logic [7:0]                  volt_type;
    logic [7:0]                  fuel_type;
    logic                        fuel_disc_en;
    logic [15:0]                 startup_ticks;
    logic [15:0]                 tick_count;
    logic                        startup_over;
    logic [btsr_pkg::VOLT_W-1:0] last_voltage;
    logic                        led;
    reply_t                      replies_due[$];
    int                          errors;

    function new();
      discover_code   = 4'd8;
      type_query_code = 4'd9;
      read_code       = 4'd10;
      volt_type       = 8'd3;
      fuel_type       = 8'd6;
      fuel_disc_en    = 1'b0;
      startup_ticks   = 16'd2;
      tick_count      = '0;
      startup_over    = 1'b0;
      last_voltage    = '0;
      led             = 1'b0;
      errors          = 0;
    endfunction

    function void write_reg(btsr_pkg::reg_index_t idx, logic [15:0] data);
      case (idx)
        btsr_pkg::REG_DISCOVER_CODE:   discover_code   = data[3:0];
        btsr_pkg::REG_TYPE_QUERY_CODE: type_query_code = data[3:0];
        btsr_pkg::REG_READ_CODE:       read_code       = data[3:0];
        btsr_pkg::REG_VOLT_TYPE_CODE:  volt_type       = data[7:0];
        btsr_pkg::REG_FUEL_TYPE_CODE:  fuel_type       = data[7:0];
        btsr_pkg::REG_FUEL_DISC_EN:    fuel_disc_en    = data[0];
        btsr_pkg::REG_STARTUP_TICKS:   startup_ticks   = data;
        default: ;
      endcase
    endfunction

    // Percent in steps of 5 from the stored voltage; full during startup.
    function logic [7:0] fuel_level();
      int pack;
      pack = -1;
      if (!startup_over && tick_count < startup_ticks)
        return btsr_pkg::FULL_PERCENT;
      startup_over = 1'b1;
      for (int s = 0; s < btsr_pkg::PACK_SIZES; s++) begin
        if (pack < 0 && last_voltage >= btsr_pkg::LEVEL_TABLE[s][0] &&
            last_voltage <= btsr_pkg::LEVEL_TABLE[s][btsr_pkg::LEVEL_ROWS-1])
          pack = s;
      end
      if (pack < 0)
        return 8'd0;
      for (int row = 0; row < btsr_pkg::LEVEL_ROWS - 1; row++) begin
        if (last_voltage > btsr_pkg::LEVEL_TABLE[pack][row] &&
            last_voltage <= btsr_pkg::LEVEL_TABLE[pack][row+1])
          return 8'(row * 5);
      end
      return 8'd0;
    endfunction

    function void take_event(btsr_pkg::mode_t m, logic [3:0] cmd, logic [3:0] id,
                             logic [9:0] sample);
      reply_t      r;
      logic [20:0] prod;
      r = '0;
      case (m)
        btsr_pkg::MODE_GOOD: begin
          if (cmd == discover_code) begin
            if (id == btsr_pkg::VOLT_SENSOR_ID ||
                (id == btsr_pkg::FUEL_SENSOR_ID && fuel_disc_en))
              r.valid = 1'b1;
          end else if (cmd == type_query_code) begin
            if (id == btsr_pkg::VOLT_SENSOR_ID || id == btsr_pkg::FUEL_SENSOR_ID) begin
              r.valid  = 1'b1;
              r.length = btsr_pkg::PAYLOAD_LEN;
              r.low    = (id == btsr_pkg::VOLT_SENSOR_ID) ? volt_type : fuel_type;
              r.high   = btsr_pkg::TYPE_HIGH_BYTE;
            end
          end else if (cmd == read_code) begin
            if (id == btsr_pkg::VOLT_SENSOR_ID) begin
              prod         = 21'(sample) * 21'(btsr_pkg::VOLT_SCALE);
              last_voltage = prod[20:8];
              r.valid      = 1'b1;
              r.length     = btsr_pkg::PAYLOAD_LEN;
              r.low        = last_voltage[7:0];
              r.high       = 8'(last_voltage >> 8);
            end else if (id == btsr_pkg::FUEL_SENSOR_ID) begin
              r.valid  = 1'b1;
              r.length = btsr_pkg::PAYLOAD_LEN;
              r.low    = fuel_level();
            end
          end
          led = 1'b1;
        end
        btsr_pkg::MODE_BAD:  led = 1'b0;
        btsr_pkg::MODE_TICK: if (tick_count != btsr_pkg::TICK_MAX) tick_count++;
        default: ;
      endcase
      if (r.valid) begin
        r.command = cmd;
        r.sensor  = id;
      end
      r.led = led;
      replies_due.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("reply transaction with no event outstanding");
        errors++;
        return;
      end
      want = replies_due.pop_front();
      check_field("reply_valid", 8'(want.valid), 8'(got.valid));
      check_field("reply_command", 8'(want.command), 8'(got.command));
      check_field("reply_sensor", 8'(want.sensor), 8'(got.sensor));
      check_field("reply_length", 8'(want.length), 8'(got.length));
      check_field("payload_low", want.low, got.low);
      check_field("payload_high", want.high, got.high);
      check_field("led_on", 8'(want.led), 8'(got.led));
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] mode;
  logic [3:0] command;
  logic [3:0] sensor_id;
  logic [9:0] adc_sample;
  logic out_valid;
  logic out_ready;
  logic reply_valid;
  logic [3:0] reply_command;
  logic [3:0] reply_sensor;
  logic [1:0] reply_length;
  logic [7:0] payload_low;
  logic [7:0] payload_high;
  logic led_on;
  logic cfg_we;
  logic [btsr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [btsr_pkg::CFG_DATA_W-1:0] cfg_data;

  reply_tracker tracker;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  battery_telemetry_sensor_responder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .command(command),
    .sensor_id(sensor_id),
    .adc_sample(adc_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .reply_valid(reply_valid),
    .reply_command(reply_command),
    .reply_sensor(reply_sensor),
    .reply_length(reply_length),
    .payload_low(payload_low),
    .payload_high(payload_high),
    .led_on(led_on),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: check each reply transaction, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        tracker.check_reply('{reply_valid, reply_command, reply_sensor, reply_length,
                              payload_low, payload_high, led_on});
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Valid is only lowered for a gap; back-to-back transactions keep it high.
  task automatic send_item(input btsr_pkg::mode_t m, input logic [3:0] cmd,
                           input logic [3:0] id, input logic [9:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    command    <= cmd;
    sensor_id  <= id;
    adc_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_event(m, cmd, id, sample);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Upper data bits beyond each register's width carry junk on purpose.
  task automatic apply_config(input logic [3:0] disc, input logic [3:0] typ,
                              input logic [3:0] rd, input logic [7:0] vt,
                              input logic [7:0] ft, input logic en,
                              input logic [15:0] st);
    btsr_pkg::reg_index_t idx;
    logic [15:0]          vals [8];
    logic [15:0]          keep [8];
    logic [15:0]          word;
    vals = '{16'(disc), 16'(typ), 16'(rd), 16'(vt), 16'(ft), 16'(en), st, 16'd0};
    keep = '{16'h000F, 16'h000F, 16'h000F, 16'h00FF, 16'h00FF, 16'h0001, 16'hFFFF,
             16'h0000};
    idx = idx.first();
    do begin
      word      = (vals[idx] & keep[idx]) | (16'($urandom) & ~keep[idx]);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= word;
      @(posedge clk);
      tracker.write_reg(idx, word);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_item();
    btsr_pkg::mode_t m;
    logic [3:0]      cmd;
    logic [3:0]      id;
    logic [9:0]      sample;
    int              pick;
    pick = $urandom_range(99);
    if (pick < 74) m = btsr_pkg::MODE_GOOD;
    else if (pick < 85) m = btsr_pkg::MODE_TICK;
    else if (pick < 96) m = btsr_pkg::MODE_BAD;
    else m = btsr_pkg::MODE_NONE;
    pick = $urandom_range(9);
    if (pick < 3) cmd = tracker.discover_code;
    else if (pick < 5) cmd = tracker.type_query_code;
    else if (pick < 9) cmd = tracker.read_code;
    else cmd = 4'($urandom);
    if ($urandom_range(9) < 8)
      id = $urandom_range(1) ? btsr_pkg::VOLT_SENSOR_ID : btsr_pkg::FUEL_SENSOR_ID;
    else
      id = 4'($urandom);
    // most samples come from a range that largely lands inside the level table of one pack size or the other
    if ($urandom_range(9) < 6)
      sample = 10'($urandom_range(240, 120));
    else
      sample = 10'($urandom);
    send_item(m, cmd, id, sample);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        // hold off until the block has returned everything
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
      end
      send_random_item();
    end
    settle();
  endtask

  initial begin
    logic [9:0] edge_samples [8];
    edge_samples = '{10'd133, 10'd134, 10'd171, 10'd172, 10'd178, 10'd179, 10'd228,
                     10'd229};
    tracker    = new();
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    mode       <= btsr_pkg::MODE_GOOD;
    command    <= '0;
    sensor_id  <= '0;
    adc_sample <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= btsr_pkg::REG_DISCOVER_CODE;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed polls with reset register values
    send_item(btsr_pkg::MODE_GOOD, tracker.discover_code, btsr_pkg::VOLT_SENSOR_ID, 10'd0);
    send_item(btsr_pkg::MODE_GOOD, tracker.discover_code, btsr_pkg::FUEL_SENSOR_ID,
              10'd1023);
    send_item(btsr_pkg::MODE_BAD, 4'd15, 4'd15, 10'd1023);
    send_item(btsr_pkg::MODE_NONE, 4'd15, 4'd15, 10'd0);
    send_item(btsr_pkg::MODE_GOOD, tracker.type_query_code, btsr_pkg::VOLT_SENSOR_ID,
              10'd0);
    send_item(btsr_pkg::MODE_GOOD, tracker.type_query_code, btsr_pkg::FUEL_SENSOR_ID,
              10'd0);
    send_item(btsr_pkg::MODE_GOOD, tracker.read_code, btsr_pkg::FUEL_SENSOR_ID, 10'd0);
    send_item(btsr_pkg::MODE_GOOD, tracker.read_code, btsr_pkg::VOLT_SENSOR_ID, 10'd1023);
    send_item(btsr_pkg::MODE_GOOD, tracker.read_code, btsr_pkg::VOLT_SENSOR_ID, 10'd0);
    send_item(btsr_pkg::MODE_TICK, 4'd0, 4'd0, 10'd0);
    send_item(btsr_pkg::MODE_GOOD, tracker.read_code, btsr_pkg::FUEL_SENSOR_ID, 10'd512);
    send_item(btsr_pkg::MODE_GOOD, 4'd0, btsr_pkg::VOLT_SENSOR_ID, 10'd0);
    send_item(btsr_pkg::MODE_GOOD, 4'd15, btsr_pkg::FUEL_SENSOR_ID, 10'd0);
    send_item(btsr_pkg::MODE_GOOD, tracker.read_code, 4'd0, 10'd200);
    send_item(btsr_pkg::MODE_GOOD, tracker.read_code, 4'd15, 10'd200);
    send_item(btsr_pkg::MODE_GOOD, tracker.discover_code, 4'd3, 10'd0);
    send_item(btsr_pkg::MODE_GOOD, tracker.type_query_code, 4'd15, 10'd0);
    send_item(btsr_pkg::MODE_BAD, 4'd0, 4'd0, 10'd0);
    send_item(btsr_pkg::MODE_GOOD, tracker.discover_code, btsr_pkg::VOLT_SENSOR_ID, 10'd0);
    settle();

    // startup window closes once the tick count reaches the register value
    apply_config(4'd8, 4'd9, 4'd10, 8'd3, 8'd6, 1'b1, 16'd6);
    send_item(btsr_pkg::MODE_GOOD, tracker.discover_code, btsr_pkg::FUEL_SENSOR_ID, 10'd0);
    for (int n = 0; n < 8; n++) begin
      send_item(btsr_pkg::MODE_GOOD, tracker.read_code, btsr_pkg::FUEL_SENSOR_ID, 10'd0);
      send_item(btsr_pkg::MODE_TICK, 4'($urandom), 4'($urandom), 10'($urandom));
    end
    // samples just around the bottom and top of both pack sizes
    foreach (edge_samples[i]) begin
      send_item(btsr_pkg::MODE_GOOD, tracker.read_code, btsr_pkg::FUEL_SENSOR_ID, 10'd0);
      send_item(btsr_pkg::MODE_GOOD, tracker.read_code, btsr_pkg::VOLT_SENSOR_ID,
                edge_samples[i]);
    end
    send_item(btsr_pkg::MODE_GOOD, tracker.read_code, btsr_pkg::FUEL_SENSOR_ID, 10'd0);
    settle();

    // all command codes equal: discovery wins
    apply_config(4'd5, 4'd5, 4'd5, 8'd0, 8'd255, 1'b1, 16'd0);
    run_random(170, 0, 0);
    // type query and read share a code: type query wins
    apply_config(4'd15, 4'd0, 4'd0, 8'd255, 8'd0, 1'b0, 16'hFFFF);
    run_random(170, 71, 0);
    apply_config(4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                 1'($urandom), 16'($urandom));
    run_random(170, 0, 71);
    apply_config(4'd0, 4'd15, 4'd7, 8'($urandom), 8'($urandom), 1'b1, 16'd0);
    run_random(170, 17, 17);
    apply_config(4'd8, 4'd9, 4'd10, 8'd3, 8'd6, 1'b0, 16'd2);
    run_random(170, 0, 0);

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
